// ===== rtl/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock.
package kcl_pkg;

	typedef enum logic [2:0] {
		MODE_MENU    = 3'd0,
		MODE_UNLOCK  = 3'd1,
		MODE_OLD     = 3'd2,
		MODE_NEW     = 3'd3,
		MODE_CONFIRM = 3'd4
	} lock_mode_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_DIGIT       = 3'd1,
		EV_WRONG       = 3'd2,
		EV_UNLOCKED    = 3'd3,
		EV_UPDATED     = 3'd4,
		EV_MISMATCH    = 3'd5,
		EV_RELEASE_END = 3'd6
	} event_t;

	localparam logic [4:0]  KEY_DIGIT_MAX    = 5'd9;
	localparam logic [4:0]  KEY_A            = 5'd10;
	localparam logic [4:0]  KEY_B            = 5'd11;
	localparam logic [4:0]  KEY_NONE         = 5'd16;
	localparam logic [15:0] UNLOCK_TICKS_RST = 16'd5000;
	localparam logic [15:0] UNLOCK_TICKS_MIN = 16'd1;

endpackage

// ===== rtl/keypad_code_lock_top.sv =====
// Keypad code lock: input register, single-step lock state machine, result register.
// A transaction is held in the input register, then registered as a result.
// Throughput: one transaction per cycle if res_stall is low; one lock step per item.
// Reset: asynchronous, active low; menu mode, empty entries, code 0000, release off,
// unlock_ticks back to 5000.
module keypad_code_lock_top #(
	parameter int CODE_LENGTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        action,
	input  logic [7:0]  scan_pattern,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  event_res,
	output logic [4:0]  key_value,
	output logic [2:0]  mode,
	output logic [2:0]  digits_entered,
	output logic        release_res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_LENGTH - 1);

	typedef logic [CODE_LENGTH-1:0][3:0] code_t;

	logic [15:0] ticks_q;

	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  scan_s1;

	logic             valid_s2;
	kcl_pkg::event_t  event_s2;
	logic [4:0]       key_s2;
	logic [2:0]       mode_s2;
	logic [2:0]       count_s2;
	logic             release_s2;

	kcl_pkg::lock_mode_t mode_q, mode_d;
	logic [CNT_W-1:0]    count_q, count_d;
	code_t               first_q, first_d, first_nx;
	code_t               second_q, second_d, second_nx;
	code_t               stored_q, stored_d;
	logic [15:0]         timer_q, timer_d, timer_load;

	logic             move_s1;
	logic             accept;
	logic [4:0]       key_s1;
	logic             busy;
	logic             in_entry;
	logic             take_digit;
	logic             last_digit;
	logic             old_ok;
	logic             pair_ok;
	kcl_pkg::event_t  event_d;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {16'd0, ticks_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= kcl_pkg::UNLOCK_TICKS_RST;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			ticks_q <= pwdata[15:0];
		end
	end

	assign move_s1    = valid_s1 && (!valid_s2 || !res_stall);
	assign item_stall = valid_s1 && !move_s1;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			scan_s1   <= scan_pattern;
		end
	end

	kcl_key_decode u_decode (
		.scan (scan_s1),
		.key  (key_s1)
	);

	assign busy       = timer_q != 16'd0;
	assign in_entry   = (mode_q == kcl_pkg::MODE_UNLOCK) || (mode_q == kcl_pkg::MODE_OLD) ||
	                    (mode_q == kcl_pkg::MODE_NEW) || (mode_q == kcl_pkg::MODE_CONFIRM);
	assign take_digit = !action_s1 && !busy && in_entry && (key_s1 <= kcl_pkg::KEY_DIGIT_MAX);
	assign last_digit = take_digit && (count_q == CNT_LAST);
	assign timer_load = (ticks_q == 16'd0) ? kcl_pkg::UNLOCK_TICKS_MIN : ticks_q;

	always_comb begin
		first_nx  = first_q;
		second_nx = second_q;
		if (take_digit) begin
			if (mode_q == kcl_pkg::MODE_CONFIRM) begin
				second_nx[count_q] = key_s1[3:0];
			end else begin
				first_nx[count_q] = key_s1[3:0];
			end
		end
	end

	assign old_ok  = first_nx == stored_q;
	assign pair_ok = first_q == second_nx;

	// next state
	always_comb begin
		mode_d   = mode_q;
		count_d  = count_q;
		first_d  = first_nx;
		second_d = second_nx;
		stored_d = stored_q;
		timer_d  = timer_q;
		if (action_s1) begin
			if (busy) begin
				timer_d = timer_q - 16'd1;
			end
		end else if (!busy) begin
			if (in_entry) begin
				if (take_digit) begin
					count_d = count_q + CNT_W'(1);
				end
				if (last_digit) begin
					count_d = '0;
					mode_d  = kcl_pkg::MODE_MENU;
					unique case (mode_q)
						kcl_pkg::MODE_UNLOCK: begin
							if (old_ok) begin
								timer_d = timer_load;
							end
						end
						kcl_pkg::MODE_OLD: begin
							if (old_ok) begin
								mode_d  = kcl_pkg::MODE_NEW;
								first_d = '0;
							end
						end
						kcl_pkg::MODE_NEW: begin
							mode_d   = kcl_pkg::MODE_CONFIRM;
							second_d = '0;
						end
						kcl_pkg::MODE_CONFIRM: begin
							if (pair_ok) begin
								stored_d = first_q;
							end
						end
						default: begin
							mode_d = kcl_pkg::MODE_MENU;
						end
					endcase
				end
			end else begin
				mode_d = kcl_pkg::MODE_MENU;
				if (key_s1 == kcl_pkg::KEY_A) begin
					mode_d  = kcl_pkg::MODE_UNLOCK;
					count_d = '0;
					first_d = '0;
				end else if (key_s1 == kcl_pkg::KEY_B) begin
					mode_d  = kcl_pkg::MODE_OLD;
					count_d = '0;
					first_d = '0;
				end
			end
		end
	end

	// event
	always_comb begin
		event_d = kcl_pkg::EV_NONE;
		if (action_s1) begin
			if (timer_q == 16'd1) begin
				event_d = kcl_pkg::EV_RELEASE_END;
			end
		end else if (take_digit) begin
			event_d = kcl_pkg::EV_DIGIT;
			if (last_digit) begin
				unique case (mode_q)
					kcl_pkg::MODE_UNLOCK:
						event_d = old_ok ? kcl_pkg::EV_UNLOCKED : kcl_pkg::EV_WRONG;
					kcl_pkg::MODE_OLD:
						event_d = old_ok ? kcl_pkg::EV_DIGIT : kcl_pkg::EV_WRONG;
					kcl_pkg::MODE_NEW:
						event_d = kcl_pkg::EV_DIGIT;
					kcl_pkg::MODE_CONFIRM:
						event_d = pair_ok ? kcl_pkg::EV_UPDATED : kcl_pkg::EV_MISMATCH;
					default:
						event_d = kcl_pkg::EV_NONE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= kcl_pkg::MODE_MENU;
			count_q  <= '0;
			first_q  <= '0;
			second_q <= '0;
			stored_q <= '0;
			timer_q  <= '0;
		end else if (move_s1) begin
			mode_q   <= mode_d;
			count_q  <= count_d;
			first_q  <= first_d;
			second_q <= second_d;
			stored_q <= stored_d;
			timer_q  <= timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			event_s2   <= event_d;
			key_s2     <= action_s1 ? kcl_pkg::KEY_NONE : key_s1;
			mode_s2    <= mode_d;
			count_s2   <= 3'(count_d);
			release_s2 <= timer_d != 16'd0;
		end
	end

	assign res_valid      = valid_s2;
	assign event_res      = event_s2;
	assign key_value      = key_s2;
	assign mode           = mode_s2;
	assign digits_entered = count_s2;
	assign release_res    = release_s2;

`ifndef SYNTHESIS
	a_unlock_releases: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (event_res == kcl_pkg::EV_UNLOCKED) |-> release_res)
		else $error("unlock event without release");

	a_release_end_drops: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (event_res == kcl_pkg::EV_RELEASE_END) |-> !release_res)
		else $error("release end event with release still high");

	a_release_in_menu: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && release_res |-> (mode == kcl_pkg::MODE_MENU))
		else $error("release high outside the menu");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (mode_q == kcl_pkg::MODE_MENU) && (count_q == '0))
		else $error("entry in progress while released");
`endif

endmodule

// ===== rtl/kcl_key_decode.sv =====
// Keypad scan pattern to key code decoder.
module kcl_key_decode (
	input  logic [7:0] scan,
	output logic [4:0] key
);

	localparam logic [0:15][7:0] KEY_PATTERNS = {
		8'hEB, 8'h77, 8'h7B, 8'h7D, 8'hB7, 8'hBB, 8'hBD, 8'hD7,
		8'hDB, 8'hDD, 8'h7E, 8'hBE, 8'hDE, 8'hEE, 8'hE7, 8'hED
	};

	logic [7:0] rev;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			rev[7 - i] = scan[i];
		end
	end

	always_comb begin
		key = kcl_pkg::KEY_NONE;
		for (int i = 0; i < 16; i++) begin
			if (KEY_PATTERNS[i] == rev) begin
				key = 5'(i);
			end
		end
	end

endmodule
